@@ hdl/cqs_pkg.sv @@
// shared types and constants for the circular queue with search
// no dependencies
package cqs_pkg;

	localparam int DATA_W    = 32;
	localparam int SLOTS_DEF = 16;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_SEARCH = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] removed_value;
		status_t                  status;
		logic                     found;
	} res_t;

endpackage

@@ hdl/cqs_slot_ram.sv @@
// slot store: one write port, one read port with registered read data
// depends on cqs_pkg
module cqs_slot_ram #(
	parameter int DEPTH = cqs_pkg::SLOTS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                                clk,
	input  logic                                wr_en,
	input  logic [AW-1:0]                       wr_addr,
	input  logic signed [cqs_pkg::DATA_W-1:0]   wr_data,
	input  logic [AW-1:0]                       rd_addr,
	output logic signed [cqs_pkg::DATA_W-1:0]   rd_data
);
	import cqs_pkg::*;

	logic signed [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

@@ hdl/cqs_ctrl.sv @@
// sequencer: head and tail indices, command decode and the search scan
// one compare against the slot read each cycle; depends on cqs_pkg
module cqs_ctrl #(
	parameter int SLOTS = cqs_pkg::SLOTS_DEF,
	parameter int IDX_W = $clog2(SLOTS)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  cqs_pkg::cmd_t                       in_cmd,
	input  logic signed [cqs_pkg::DATA_W-1:0]   in_data,
	output logic                                wr_en,
	output logic [IDX_W-1:0]                    wr_addr,
	output logic signed [cqs_pkg::DATA_W-1:0]   wr_data,
	output logic [IDX_W-1:0]                    rd_addr,
	input  logic signed [cqs_pkg::DATA_W-1:0]   rd_data,
	input  logic                                out_free,
	output logic                                done,
	output cqs_pkg::res_t                       res
);
	import cqs_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_RDWAIT = 4'b0010,
		S_SCAN   = 4'b0100,
		S_DONE   = 4'b1000
	} state_t;

	function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
		return (idx == IDX_W'(SLOTS - 1)) ? '0 : idx + 1'b1;
	endfunction

	state_t                   state_q;
	logic [IDX_W-1:0]         head_q;
	logic [IDX_W-1:0]         tail_q;
	logic [IDX_W-1:0]         cur_q;
	logic signed [DATA_W-1:0] key_q;
	res_t                     res_q;

	logic [IDX_W-1:0] head_nxt;
	logic [IDX_W-1:0] tail_nxt;
	logic [IDX_W-1:0] cur_nxt;
	logic             full;
	logic             empty;
	logic             accept;

	always_comb begin
		head_nxt = ring_next(head_q);
		tail_nxt = ring_next(tail_q);
		cur_nxt  = ring_next(cur_q);
		full     = (tail_nxt == head_q);
		empty    = (head_q == tail_q);
		in_ready = (state_q == S_IDLE);
		accept   = in_valid && in_ready;
		wr_en    = accept && (in_cmd == CMD_INSERT) && !full;
		wr_addr  = tail_nxt;
		wr_data  = in_data;
		rd_addr  = (state_q == S_IDLE) ? head_nxt : cur_nxt;
		done     = (state_q == S_DONE) && out_free;
		res      = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						case (in_cmd)
							CMD_INSERT: begin
								if (!full) begin
									tail_q <= tail_nxt;
								end
								state_q <= S_DONE;
							end
							CMD_DELETE: begin
								if (empty) begin
									state_q <= S_DONE;
								end else begin
									head_q  <= head_nxt;
									state_q <= S_RDWAIT;
								end
							end
							CMD_SEARCH: begin
								state_q <= empty ? S_DONE : S_SCAN;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_RDWAIT: begin
					state_q <= S_DONE;
				end
				S_SCAN: begin
					if ((rd_data == key_q) || (cur_q == tail_q)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result and scan payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cur_q <= head_nxt;
					key_q <= in_data;
					if (in_cmd == CMD_INSERT && full) begin
						res_q <= '{removed_value: '0, status: ST_FULL, found: 1'b0};
					end else if (in_cmd == CMD_DELETE && empty) begin
						res_q <= '{removed_value: '0, status: ST_EMPTY, found: 1'b0};
					end else begin
						res_q <= '0;
					end
				end
			end
			S_RDWAIT: begin
				res_q.removed_value <= rd_data;
			end
			S_SCAN: begin
				if (rd_data == key_q) begin
					res_q.found <= 1'b1;
				end else if (cur_q != tail_q) begin
					cur_q <= cur_nxt;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ hdl/circular_queue_with_search.sv @@
// top level of the circular queue with search: sequencer, slot store, output register
// depends on cqs_pkg, cqs_slot_ram and cqs_ctrl
//
// usage:
//   one request beat on the s_ channel: s_tuser is the command (insert, delete,
//   search), s_tdata the word to insert or look for. every request gives
//   exactly one result beat on the m_ channel: m_tdata the removed word,
//   m_tuser the status and the found flag.
//   the queue holds up to SLOTS-1 words; an insert into a full queue is
//   dropped with a full status, a delete from an empty queue is refused
//   with an empty status.
// timing:
//   insert and unused commands: the sequencer goes from idle straight to its
//   result state. delete: a read-wait state first, for the registered slot read.
//   search: a scan state compares the stored words in turn until a match or
//   the newest word, at most SLOTS-1 words; the slot read port gives
//   one word per cycle to the single comparator.
//   s_tready is high only while the sequencer is idle, one request at a time.
// reset clears head and tail, so the queue starts empty; no result is held.
// when the receiver stalls the result waits in the output register and the
// next request is taken, but its result waits until that register is free.
module circular_queue_with_search #(
	parameter int SLOTS = cqs_pkg::SLOTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [cqs_pkg::DATA_W-1:0]          s_tdata,  // data_value
	input  logic [1:0]                          s_tuser,  // command
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [cqs_pkg::DATA_W-1:0]          m_tdata,  // removed_value
	output logic [2:0]                          m_tuser   // status, found
);
	import cqs_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);

	logic                     wr_en;
	logic [IDX_W-1:0]         wr_addr;
	logic signed [DATA_W-1:0] wr_data;
	logic [IDX_W-1:0]         rd_addr;
	logic signed [DATA_W-1:0] rd_data;
	logic                     out_free;
	logic                     done;
	res_t                     res;
	logic                     m_tvalid_q;
	res_t                     out_q;

	cqs_ctrl #(
		.SLOTS (SLOTS),
		.IDX_W (IDX_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_cmd   (cmd_t'(s_tuser)),
		.in_data  (signed'(s_tdata)),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.out_free (out_free),
		.done     (done),
		.res      (res)
	);

	cqs_slot_ram #(
		.DEPTH (SLOTS),
		.AW    (IDX_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = unsigned'(out_q.removed_value);
	assign m_tuser  = {out_q.found, out_q.status};

endmodule
